/* src/mrhr_pkg.sv */
// Package: constants, register codes and CRC-16 byte update for the Modbus responder.
`timescale 1ns / 1ps

package mrhr_pkg;

    localparam int unsigned RX_BUFFER_BYTES = 256;
    localparam int unsigned CNT_W = $clog2(RX_BUFFER_BYTES + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_READ_COILS  = 8'h01;
    localparam logic [7:0] REPLY_BYTE_CNT = 8'h01;
    localparam logic [7:0] DATA_ZERO      = 8'h00;
    localparam logic [7:0] DATA_ONE       = 8'h01;

    // register indexes (paddr[2])
    localparam logic REG_DEVICE_ADDRESS    = 1'b0;
    localparam logic REG_BROADCAST_ADDRESS = 1'b1;

    localparam logic [7:0] DEVICE_ADDRESS_RST    = 8'h01;
    localparam logic [7:0] BROADCAST_ADDRESS_RST = 8'h00;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_IDLE = 1'b1;

    localparam int unsigned REPLY_LEN = 7;
    localparam int unsigned REM_W = $clog2(REPLY_LEN + 1);

    // remaining-byte codes of the reply sequencer
    localparam logic [REM_W-1:0] REM_DEV   = REM_W'(7);
    localparam logic [REM_W-1:0] REM_FC    = REM_W'(6);
    localparam logic [REM_W-1:0] REM_CNT   = REM_W'(5);
    localparam logic [REM_W-1:0] REM_D1    = REM_W'(4);
    localparam logic [REM_W-1:0] REM_D2    = REM_W'(3);
    localparam logic [REM_W-1:0] REM_CRCL  = REM_W'(2);
    localparam logic [REM_W-1:0] REM_CRCH  = REM_W'(1);
    localparam logic [REM_W-1:0] REM_NONE  = REM_W'(0);

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* src/modbus_rtu_handshake_responder.sv */
// Top level: Modbus RTU request checker and reply generator with APB registers.
`timescale 1ns / 1ps

// Takes one item per cycle on the slave side: a received byte (tuser 0) or a
// line-idle mark (tuser 1). Bytes update the running CRC-16 and are always
// taken; an idle mark is held off while an earlier reply still has bytes
// waiting to enter the output register. A matching request yields a
// seven-byte reply on the master side, its first byte loaded into the output
// register by the reply sequencer after the idle mark is taken and the rest
// following at one byte per cycle while tready stays high, its CRC built byte by
// byte as the bytes go out through the single output register; tlast marks the
// CRC high byte.
module modbus_rtu_handshake_responder
    import mrhr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] tx_byte
    output logic        m_tlast,   // last_byte
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]       dev_addr_reg;
    logic [7:0]       bcast_addr_reg;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]      lagged_crc_reg, lagged_crc_next;
    logic [15:0]      held_tail_reg, held_tail_next;
    logic [31:0]      header_reg, header_next;

    logic [REM_W-1:0] rem_reg, rem_next;
    logic [7:0]       rep_dev_reg, rep_dev_next;
    logic [7:0]       rep_d1_reg, rep_d1_next;
    logic [7:0]       rep_d2_reg, rep_d2_next;
    logic [15:0]      tx_crc_reg, tx_crc_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg, out_last_next;

    logic             in_acc;
    logic             frame_ok;
    logic             pair_ok;
    logic [15:0]      recv_crc;
    logic             load;
    logic [7:0]       load_byte;
    logic [7:0]       a0, fc, d1, d2;

    assign pready   = 1'b1;
    assign s_tready = !(s_tuser == REQ_IDLE && rem_reg != REM_NONE);
    assign in_acc   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        case (paddr[2])
            REG_DEVICE_ADDRESS:    prdata = {24'h0, dev_addr_reg};
            REG_BROADCAST_ADDRESS: prdata = {24'h0, bcast_addr_reg};
            default:               prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg   <= DEVICE_ADDRESS_RST;
            bcast_addr_reg <= BROADCAST_ADDRESS_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_DEVICE_ADDRESS:    dev_addr_reg   <= pwdata[7:0];
                REG_BROADCAST_ADDRESS: bcast_addr_reg <= pwdata[7:0];
                default:               ;
            endcase
        end
    end

    // frame check, from stored state only
    assign a0       = header_reg[7:0];
    assign fc       = header_reg[15:8];
    assign d1       = header_reg[23:16];
    assign d2       = header_reg[31:24];
    assign recv_crc = {held_tail_reg[7:0], held_tail_reg[15:8]};
    assign pair_ok  = (d1 == DATA_ZERO && d2 == DATA_ZERO)
                   || (d1 == DATA_ZERO && d2 == DATA_ONE)
                   || (d1 == DATA_ONE  && d2 == DATA_ONE);
    assign frame_ok = (byte_count_reg >= CNT_W'(4)) && (recv_crc == lagged_crc_reg)
                   && (a0 == bcast_addr_reg) && (fc == FC_READ_COILS) && pair_ok;

    // receive side
    always_comb
    begin
        byte_count_next = byte_count_reg;
        lagged_crc_next = lagged_crc_reg;
        held_tail_next  = held_tail_reg;
        header_next     = header_reg;
        rep_dev_next    = rep_dev_reg;
        rep_d1_next     = rep_d1_reg;
        rep_d2_next     = rep_d2_reg;
        if (in_acc)
        begin
            if (s_tuser == REQ_BYTE)
            begin
                if (byte_count_reg < CNT_W'(RX_BUFFER_BYTES))
                begin
                    if (byte_count_reg >= CNT_W'(2))
                        lagged_crc_next = crc_feed(lagged_crc_reg, held_tail_reg[15:8]);
                    held_tail_next = {held_tail_reg[7:0], s_tdata};
                    if (byte_count_reg < CNT_W'(4))
                        header_next[byte_count_reg[1:0]*8 +: 8] = s_tdata;
                    byte_count_next = byte_count_reg + CNT_W'(1);
                end
            end
            else if (byte_count_reg != '0)
            begin
                if (frame_ok)
                begin
                    rep_dev_next = dev_addr_reg;
                    rep_d1_next  = d1;
                    rep_d2_next  = d2;
                end
                byte_count_next = '0;
                lagged_crc_next = CRC_INIT;
                held_tail_next  = '0;
                header_next     = '0;
            end
        end
    end

    // reply sequencer feeding the output register
    always_comb
    begin
        case (rem_reg)
            REM_DEV:  load_byte = rep_dev_reg;
            REM_FC:   load_byte = FC_READ_COILS;
            REM_CNT:  load_byte = REPLY_BYTE_CNT;
            REM_D1:   load_byte = rep_d1_reg;
            REM_D2:   load_byte = rep_d2_reg;
            REM_CRCL: load_byte = tx_crc_reg[7:0];
            REM_CRCH: load_byte = tx_crc_reg[15:8];
            default:  load_byte = 8'h00;
        endcase
    end

    assign load = (rem_reg != REM_NONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        rem_next       = rem_reg;
        tx_crc_next    = tx_crc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = load_byte;
            out_last_next  = (rem_reg == REM_CRCH);
            rem_next       = rem_reg - REM_W'(1);
            if (rem_reg > REM_CRCL)
                tx_crc_next = crc_feed(tx_crc_reg, load_byte);
        end
        else if (in_acc && s_tuser == REQ_IDLE && byte_count_reg != '0 && frame_ok)
        begin
            rem_next    = REM_DEV;
            tx_crc_next = CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            lagged_crc_reg <= CRC_INIT;
            held_tail_reg  <= '0;
            header_reg     <= '0;
            rem_reg        <= REM_NONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            lagged_crc_reg <= lagged_crc_next;
            held_tail_reg  <= held_tail_next;
            header_reg     <= header_next;
            rem_reg        <= rem_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_dev_reg  <= rep_dev_next;
        rep_d1_reg   <= rep_d1_next;
        rep_d2_reg   <= rep_d2_next;
        tx_crc_reg   <= tx_crc_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // an idle mark is only taken with the reply sequencer empty
    a_idle_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser == REQ_IDLE) |-> (rem_reg == REM_NONE))
        else $error("idle accepted while reply pending");

    // any accepted idle leaves an empty frame
    a_idle_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser == REQ_IDLE) |=> (byte_count_reg == '0 && header_reg == '0))
        else $error("frame state not cleared after idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CNT_W'(RX_BUFFER_BYTES))
        else $error("byte count beyond buffer size");

    // tlast is loaded exactly when the sequencer runs out
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && rem_reg == REM_CRCH) |=> (m_tvalid && m_tlast && rem_reg == REM_NONE))
        else $error("reply end mismatch");

endmodule

/* tb/tb_modbus_rtu_handshake_responder.sv */
// Testbench: Modbus RTU responder checked against a CRC-16 frame predictor.
`timescale 1ns / 1ps

module tb_modbus_rtu_handshake_responder;
    import mrhr_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 32;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
    logic        s_tuser = 1'b0;    // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] tx_byte
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'b000;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    int          rx_count;
    logic [15:0] running_crc;
    logic [15:0] tail_bytes;
    logic [31:0] header;
    logic [7:0]  dev_addr;
    logic [7:0]  bcast_addr;

    reply_byte_t reply_q[$];
    reply_byte_t want;
    logic [7:0]  frame_buf[$];

    int mismatches = 0;
    int items_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;

    modbus_rtu_handshake_responder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb_modbus_rtu_handshake_responder: FAIL");
        $finish;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, exp_val);
        mismatches++;
    endtask

    task automatic clear_frame_state();
        rx_count    = 0;
        running_crc = CRC_INIT;
        tail_bytes  = 16'h0000;
        header      = 32'h0;
    endtask

    // Works out the reply bytes that one accepted item causes.
    task automatic predict_item(input logic kind, input logic [7:0] b);
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [15:0] trailer;
        logic [15:0] c;
        logic        pair_ok;
        logic [7:0]  reply [7];
        reply_byte_t rb;
        if (kind == REQ_BYTE)
        begin
            if (rx_count >= RX_BUFFER_BYTES)
                return;   // buffer full, byte dropped
            if (rx_count >= 2)
                running_crc = crc16_update(running_crc, tail_bytes[15:8]);
            tail_bytes = {tail_bytes[7:0], b};
            if (rx_count < 4)
                header[8*rx_count +: 8] = b;
            rx_count++;
            return;
        end
        if (rx_count == 0)
            return;
        d1 = header[23:16];
        d2 = header[31:24];
        trailer = {tail_bytes[7:0], tail_bytes[15:8]};   // low byte came first
        pair_ok = (d1 == DATA_ZERO && d2 == DATA_ZERO) || (d1 == DATA_ZERO && d2 == DATA_ONE)
                  || (d1 == DATA_ONE && d2 == DATA_ONE);
        if (rx_count >= 4 && trailer == running_crc && header[7:0] == bcast_addr
            && header[15:8] == FC_READ_COILS && pair_ok)
        begin
            reply[0] = dev_addr;
            reply[1] = FC_READ_COILS;
            reply[2] = REPLY_BYTE_CNT;
            reply[3] = d1;
            reply[4] = d2;
            c = CRC_INIT;
            for (int i = 0; i < 5; i++)
                c = crc16_update(c, reply[i]);
            reply[5] = c[7:0];
            reply[6] = c[15:8];
            for (int i = 0; i < 7; i++)
            begin
                rb.data = reply[i];
                rb.last = (i == 6);
                reply_q.push_back(rb);
            end
        end
        clear_frame_state();
    endtask

    // Offers one item and returns in the time step of its acceptance, valid left high.
    task automatic send_item(input logic kind, input logic [7:0] b);
        bit gap;
        gap = ($urandom_range(99) < idle_pct);
        if (gap)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(kind, b);
        items_sent++;
    endtask

    // Lowers valid, waits until every reply byte has come, then lets the block settle.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom_range(16'hFFFF, 0)), 8'($urandom_range(255, 0)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_DEVICE_ADDRESS)
            dev_addr = value;
        else
            bcast_addr = value;
        @(posedge clk);
    endtask

    task automatic set_addresses(input logic [7:0] dev, input logic [7:0] bcast);
        write_register(REG_DEVICE_ADDRESS, dev);
        write_register(REG_BROADCAST_ADDRESS, bcast);
    endtask

    task automatic pick_pair(output logic [7:0] d1, output logic [7:0] d2);
        case ($urandom_range(2))
            0:
            begin
                d1 = DATA_ZERO;
                d2 = DATA_ZERO;
            end
            1:
            begin
                d1 = DATA_ZERO;
                d2 = DATA_ONE;
            end
            default:
            begin
                d1 = DATA_ONE;
                d2 = DATA_ONE;
            end
        endcase
    endtask

    // Request bytes with trailing CRC, low byte first; extra random bytes after the header.
    task automatic build_request(input logic [7:0] addr, input logic [7:0] fc,
                                 input logic [7:0] d1, input logic [7:0] d2,
                                 input int extra, input bit bad_crc);
        logic [15:0] c;
        frame_buf.delete();
        frame_buf.push_back(addr);
        frame_buf.push_back(fc);
        frame_buf.push_back(d1);
        frame_buf.push_back(d2);
        for (int i = 0; i < extra; i++)
            frame_buf.push_back(8'($urandom_range(255)));
        c = CRC_INIT;
        foreach (frame_buf[i])
            c = crc16_update(c, frame_buf[i]);
        if (bad_crc)
            c = c ^ (16'h0001 << $urandom_range(15));
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i])
            send_item(REQ_BYTE, frame_buf[i]);
        send_item(REQ_IDLE, 8'($urandom_range(255)));
    endtask

    task automatic send_good_request(input int extra);
        logic [7:0] d1;
        logic [7:0] d2;
        pick_pair(d1, d2);
        build_request(bcast_addr, FC_READ_COILS, d1, d2, extra, 1'b0);
        send_frame();
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_item(REQ_IDLE, 8'hFF);                       // idle with nothing received
        build_request(bcast_addr, FC_READ_COILS, DATA_ZERO, DATA_ZERO, 0, 1'b0);
        send_frame();
        build_request(bcast_addr, FC_READ_COILS, DATA_ZERO, DATA_ONE, 0, 1'b0);
        send_frame();
        build_request(bcast_addr, FC_READ_COILS, DATA_ONE, DATA_ONE, 2, 1'b0);
        send_frame();
        build_request(bcast_addr, FC_READ_COILS, DATA_ONE, DATA_ZERO, 0, 1'b0); // unknown pair
        send_frame();
        build_request(bcast_addr, FC_READ_COILS, DATA_ZERO, DATA_ONE, 0, 1'b1); // CRC mismatch
        send_frame();
        build_request(8'hFF, FC_READ_COILS, DATA_ZERO, DATA_ZERO, 0, 1'b0);     // wrong address
        send_frame();
        build_request(bcast_addr, 8'h03, DATA_ZERO, DATA_ZERO, 0, 1'b0);        // wrong function
        send_frame();
        for (int n = 1; n <= 4; n++)
        begin
            // short frames, then a bare four-byte one
            for (int i = 0; i < n; i++)
                send_item(REQ_BYTE, (i % 2) ? 8'h00 : 8'hFF);
            send_item(REQ_IDLE, 8'h00);
        end
        quiesce();
    endtask

    // Exactly a full buffer of valid request, then bytes that must be dropped.
    task automatic test_buffer_full();
        build_request(bcast_addr, FC_READ_COILS, DATA_ONE, DATA_ONE, RX_BUFFER_BYTES - 6, 1'b0);
        frame_buf.push_back(8'hFF);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'hA5);
        send_frame();
        quiesce();
    endtask

    // Receiver held off while requests keep coming, so an idle mark has to wait.
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_left = 300;
        for (int i = 0; i < 4; i++)
            send_good_request(0);
        quiesce();
        // sender pauses until each reply is out
        for (int i = 0; i < 3; i++)
        begin
            send_good_request($urandom_range(2));
            quiesce();
        end
    endtask

    task automatic test_random_phase(input int idle, input int stall);
        int start;
        int pick;
        logic [7:0] d1;
        logic [7:0] d2;
        idle_pct = idle;
        stall_pct = stall;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_good_request(($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(3));
            else if (pick < 95)
            begin
                pick_pair(d1, d2);
                case ($urandom_range(5))
                    0: build_request(8'($urandom_range(255)), FC_READ_COILS, d1, d2, 0, 1'b0);
                    1: build_request(bcast_addr, 8'($urandom_range(255)), d1, d2, 0, 1'b0);
                    2: build_request(bcast_addr, FC_READ_COILS, 8'($urandom_range(255)),
                                     8'($urandom_range(255)), 0, 1'b0);
                    3: build_request(bcast_addr, FC_READ_COILS, d1, d2, $urandom_range(3), 1'b1);
                    4:
                    begin
                        frame_buf.delete();
                        repeat ($urandom_range(3, 1))
                            frame_buf.push_back(8'($urandom_range(255)));
                    end
                    default: frame_buf.delete();   // lone idle mark
                endcase
                send_frame();
            end
            else
                quiesce();
        end
        quiesce();
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (reply_q.size() == 0)
                report_mismatch("reply byte with none pending", m_tdata, 0);
            else
            begin
                want = reply_q.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch("tx_byte", m_tdata, want.data);
                if (m_tlast !== want.last)
                    report_mismatch("last_byte", m_tlast, want.last);
            end
        end
    end

    // receiver: random stalls, or a counted hold-off
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        clear_frame_state();
        dev_addr   = DEVICE_ADDRESS_RST;
        bcast_addr = BROADCAST_ADDRESS_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_buffer_full();
        set_addresses(8'h00, 8'hFF);
        test_random_phase(0, 0);
        set_addresses(8'hFF, 8'h00);
        test_random_phase(85, 0);
        set_addresses(8'($urandom_range(255)), 8'($urandom_range(255)));
        test_random_phase(0, 85);
        test_backpressure();
        set_addresses(8'($urandom_range(255)), 8'($urandom_range(255)));
        test_random_phase(17, 17);

        quiesce();
        if (reply_q.size() != 0)
            report_mismatch("replies left over", 0, reply_q.size());
        if (mismatches == 0)
            $display("tb_modbus_rtu_handshake_responder: PASS");
        else
            $display("tb_modbus_rtu_handshake_responder: FAIL");
        $finish;
    end

endmodule

/* modbus_rtu_handshake_responder.f */
src/mrhr_pkg.sv
src/modbus_rtu_handshake_responder.sv
tb/tb_modbus_rtu_handshake_responder.sv
